FILE: hw/rtl/rcbp_pkg.sv
`timescale 1ns / 1ps
// rcbp_pkg: widths, types, register codes and saturation helpers of the rc band-pass block
// used by the interfaces, the serial multiplier, the top level and the checker
package rcbp_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int FRACTION_BITS = 8;
  localparam int FACTOR_WIDTH  = 16;

  localparam int STATE_WIDTH   = SAMPLE_WIDTH + FRACTION_BITS;
  localparam int MAG_WIDTH     = STATE_WIDTH + 2;
  localparam int CFG_WIDTH     = FACTOR_WIDTH;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int CNT_WIDTH     = $clog2(FACTOR_WIDTH + 1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [STATE_WIDTH-1:0]  state_t;
  typedef logic signed [MAG_WIDTH-1:0]    wide_t;
  typedef logic        [MAG_WIDTH-1:0]    mag_t;
  typedef logic        [FACTOR_WIDTH-1:0] factor_t;
  typedef logic        [CNT_WIDTH-1:0]    cnt_t;

  localparam factor_t HP_FACTOR_RESET = FACTOR_WIDTH'(65000);
  localparam factor_t LP_FACTOR_RESET = FACTOR_WIDTH'(20000);

  localparam state_t  STATE_MAX  = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam state_t  STATE_MIN  = {1'b1, {(STATE_WIDTH-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  localparam logic [STATE_WIDTH:0] ROUND_ADD =
    (STATE_WIDTH+1)'((64'd1 << FRACTION_BITS) >> 1);

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_HP_FACTOR = 2'd0,
    CFG_LP_FACTOR = 2'd1,
    CFG_BYPASS    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic    start;
    mag_t    mag;
    factor_t factor;
  } smul_req_t;

  typedef struct packed {
    logic done;
    mag_t q;
  } smul_rsp_t;

  function automatic state_t sat_state(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = MAG_WIDTH'(STATE_MAX);
    lo = MAG_WIDTH'(STATE_MIN);
    if (v > hi) begin
      return STATE_MAX;
    end else if (v < lo) begin
      return STATE_MIN;
    end
    return v[STATE_WIDTH-1:0];
  endfunction

  // round to nearest with ties away from zero, then saturate to the sample width
  function automatic sample_t round_out(input state_t v);
    logic signed [STATE_WIDTH:0]   ve;
    logic        [STATE_WIDTH:0]   m;
    logic        [STATE_WIDTH:0]   r;
    logic signed [STATE_WIDTH+1:0] s;
    logic signed [STATE_WIDTH+1:0] hi;
    logic signed [STATE_WIDTH+1:0] lo;
    ve = (STATE_WIDTH+1)'(v);
    m  = ve[STATE_WIDTH] ? $unsigned(-ve) : $unsigned(ve);
    r  = (m + ROUND_ADD) >> FRACTION_BITS;
    s  = $signed({1'b0, r});
    if (ve[STATE_WIDTH]) begin
      s = -s;
    end
    hi = (STATE_WIDTH+2)'(SAMPLE_MAX);
    lo = (STATE_WIDTH+2)'(SAMPLE_MIN);
    if (s > hi) begin
      return SAMPLE_MAX;
    end else if (s < lo) begin
      return SAMPLE_MIN;
    end
    return s[SAMPLE_WIDTH-1:0];
  endfunction

endpackage

FILE: hw/rtl/rcbp_if.sv
`timescale 1ns / 1ps
// rcbp_in_if, rcbp_out_if: valid/ready channels for input and result items
// depends on rcbp_pkg for the sample type
interface rcbp_in_if;
  import rcbp_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface rcbp_out_if;
  import rcbp_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

FILE: hw/rtl/rcbp_smul.sv
`timescale 1ns / 1ps
// rcbp_smul: serial-parallel multiplier, one factor bit per cycle, rounded q0 product
// depends on rcbp_pkg for widths and the request and response structs
module rcbp_smul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rcbp_pkg::smul_req_t req_i,
  output rcbp_pkg::smul_rsp_t rsp_o
);
  import rcbp_pkg::*;

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  cnt_t           cnt_q, cnt_d;
  mag_t           mag_q;
  factor_t        fac_q;
  mag_t           acc_q;
  logic           rbit_q;
  logic [MAG_WIDTH:0] sum;

  assign sum = {1'b0, acc_q} + (fac_q[0] ? {1'b0, mag_q} : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CNT_WIDTH'(FACTOR_WIDTH);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_WIDTH'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // partial product shifts right, the last bit out is the rounding bit
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mag_q  <= req_i.mag;
      fac_q  <= req_i.factor;
      acc_q  <= '0;
      rbit_q <= 1'b0;
    end else if (busy_q) begin
      fac_q  <= fac_q >> 1;
      acc_q  <= sum[MAG_WIDTH:1];
      rbit_q <= sum[0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = acc_q + MAG_WIDTH'(rbit_q);

endmodule

FILE: hw/rtl/rc_bandpass_filter_step.sv
`timescale 1ns / 1ps
// rc_bandpass_filter_step: first-order rc high-pass then low-pass on signed samples
// depends on rcbp_pkg, rcbp_in_if, rcbp_out_if and rcbp_smul
//
// Usage
//   in_i carries one signed sample per item, out_o one band-passed sample per item.
//   An item is taken when valid and ready are both high. The block works on one
//   item at a time: in_i.ready is high only while the filter is idle.
//   A filtered item passes, for each of the two stages, a difference step, the
//   shared bit-serial multiplier (16 factor bits, one per cycle), a sign step and
//   an update step; then the output register is loaded. In bypass an item goes
//   straight to the output register and the filter state is left alone. The next
//   item can be taken while a result still waits in the output register.
//   If out_o.ready stays low the result holds in the output register; a further
//   finished result waits in the engine until the register frees.
//   Reset clears the filter state, loads the factor defaults (65000, 20000) and
//   clears bypass. Configuration is written through cfg_we_i / cfg_idx_i /
//   cfg_data_i while the block is idle; the user is bound to this, and the block
//   itself does not enforce it. Unknown indexes are ignored.
module rc_bandpass_filter_step (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rcbp_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx_i,
  input  logic [rcbp_pkg::CFG_WIDTH-1:0]       cfg_data_i,
  rcbp_in_if.sink                              in_i,
  rcbp_out_if.source                           out_o
);
  import rcbp_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_DIFF_HP = 10'b00_0000_0010,
    ST_MUL_HP  = 10'b00_0000_0100,
    ST_SIGN_HP = 10'b00_0000_1000,
    ST_UPD_HP  = 10'b00_0001_0000,
    ST_DIFF_LP = 10'b00_0010_0000,
    ST_MUL_LP  = 10'b00_0100_0000,
    ST_SIGN_LP = 10'b00_1000_0000,
    ST_UPD_LP  = 10'b01_0000_0000,
    ST_EMIT    = 10'b10_0000_0000
  } state_e;

  state_e    state_q, state_d;
  factor_t   hp_factor_q, lp_factor_q;
  logic      bypass_q;
  sample_t   prev_q;
  state_t    hp_q, lp_q;
  sample_t   x_q;
  logic      byp_item_q;
  logic      sign_q;
  wide_t     qs_q;
  logic      out_valid_q;
  sample_t   out_q;

  logic                    in_take;
  logic                    out_free;
  logic signed [SAMPLE_WIDTH:0] x_diff;
  wide_t                   diff;
  smul_req_t               mul_req;
  smul_rsp_t               mul_rsp;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_take    = in_i.valid && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_q;

  assign x_diff = (SAMPLE_WIDTH+1)'(x_q) - (SAMPLE_WIDTH+1)'(prev_q);

  always_comb begin
    if (state_q == ST_DIFF_LP) begin
      diff = MAG_WIDTH'(hp_q) - MAG_WIDTH'(lp_q);
    end else begin
      diff = MAG_WIDTH'(hp_q) + (MAG_WIDTH'(x_diff) <<< FRACTION_BITS);
    end
  end

  assign mul_req.start  = (state_q == ST_DIFF_HP) || (state_q == ST_DIFF_LP);
  assign mul_req.mag    = diff[MAG_WIDTH-1] ? $unsigned(-diff) : $unsigned(diff);
  assign mul_req.factor = (state_q == ST_DIFF_LP) ? lp_factor_q : hp_factor_q;

  rcbp_smul u_smul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = bypass_q ? ST_EMIT : ST_DIFF_HP;
        end
      end
      ST_DIFF_HP: state_d = ST_MUL_HP;
      ST_MUL_HP: begin
        if (mul_rsp.done) begin
          state_d = ST_SIGN_HP;
        end
      end
      ST_SIGN_HP: state_d = ST_UPD_HP;
      ST_UPD_HP:  state_d = ST_DIFF_LP;
      ST_DIFF_LP: state_d = ST_MUL_LP;
      ST_MUL_LP: begin
        if (mul_rsp.done) begin
          state_d = ST_SIGN_LP;
        end
      end
      ST_SIGN_LP: state_d = ST_UPD_LP;
      ST_UPD_LP:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hp_factor_q <= HP_FACTOR_RESET;
      lp_factor_q <= LP_FACTOR_RESET;
      bypass_q    <= 1'b0;
      prev_q      <= '0;
      hp_q        <= '0;
      lp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_HP_FACTOR: hp_factor_q <= cfg_data_i[FACTOR_WIDTH-1:0];
          CFG_LP_FACTOR: lp_factor_q <= cfg_data_i[FACTOR_WIDTH-1:0];
          CFG_BYPASS:    bypass_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (state_q == ST_UPD_HP) begin
        hp_q   <= sat_state(qs_q);
        prev_q <= x_q;
      end
      if (state_q == ST_UPD_LP) begin
        lp_q <= sat_state(MAG_WIDTH'(lp_q) + qs_q);
      end
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_q        <= in_i.sample_in;
      byp_item_q <= bypass_q;
    end
    if (mul_req.start) begin
      sign_q <= diff[MAG_WIDTH-1];
    end
    if (state_q == ST_SIGN_HP || state_q == ST_SIGN_LP) begin
      qs_q <= sign_q ? -$signed(mul_rsp.q) : $signed(mul_rsp.q);
    end
    if (state_q == ST_EMIT && out_free) begin
      out_q <= byp_item_q ? x_q : round_out(lp_q);
    end
  end

endmodule

FILE: hw/rtl/rcbp_checker.sv
`timescale 1ns / 1ps
// rcbp_checker: port-level assertions for rc_bandpass_filter_step, bound to the top level
// depends on rcbp_pkg for the sample width
module rcbp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [rcbp_pkg::SAMPLE_WIDTH-1:0] out_sample_i
);
  import rcbp_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_sample_i))
    else $error("result item changed while stalled");

  // one item in the engine at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while busy");

  // nothing offered once reset has been seen
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result offered during reset");

endmodule

bind rc_bandpass_filter_step rcbp_checker u_rcbp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample_out)
);

FILE: test/rcbp_checker.sv
`timescale 1ns / 1ps
// rcbp_scoreboard: watches the sample channels and configuration writes of the rc band-pass block
// predicts each band-passed sample and compares it in order; depends on rcbp_pkg and rcbp_if
module rcbp_scoreboard
  import rcbp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]     cfg_data_i,
  rcbp_in_if                       in_mon,
  rcbp_out_if                      out_mon,
  output int                       fail_count_o,
  output int                       outstanding_o
);

  localparam int REPORT_LIMIT = 10;

  factor_t hp_factor;
  factor_t lp_factor;
  logic    bypass;
  sample_t last_sample;
  state_t  hp_model;
  state_t  lp_model;
  sample_t expected_samples[$];
  sample_t want;
  int      mismatches;

  function automatic longint clamp(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // magnitude times factor, rounded half away from zero
  function automatic longint scale_by_factor(input longint d, input factor_t a);
    longint m;
    longint q;
    m = (d < 0) ? -d : d;
    q = (m * longint'(a) + (longint'(1) <<< (FACTOR_WIDTH - 1))) >>> FACTOR_WIDTH;
    return (d < 0) ? -q : q;
  endfunction

  function automatic longint drop_fraction(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    return (v < 0) ? -m : m;
  endfunction

  function automatic sample_t bandpass_step(input sample_t x);
    longint diff;
    longint hp;
    longint lp;
    if (bypass) begin
      return x;
    end
    diff = longint'(hp_model) + (longint'(x) <<< FRACTION_BITS)
           - (longint'(last_sample) <<< FRACTION_BITS);
    hp = clamp(scale_by_factor(diff, hp_factor), STATE_WIDTH);
    lp = clamp(longint'(lp_model) + scale_by_factor(hp - longint'(lp_model), lp_factor),
               STATE_WIDTH);
    hp_model    = state_t'(hp);
    lp_model    = state_t'(lp);
    last_sample = x;
    return sample_t'(clamp(drop_fraction(lp), SAMPLE_WIDTH));
  endfunction

  task automatic flag(input string msg);
    if (mismatches < REPORT_LIMIT) begin
      $display("%0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_factor   = HP_FACTOR_RESET;
      lp_factor   = LP_FACTOR_RESET;
      bypass      = 1'b0;
      last_sample = '0;
      hp_model    = '0;
      lp_model    = '0;
      mismatches  = 0;
      expected_samples.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HP_FACTOR: hp_factor = cfg_data_i[FACTOR_WIDTH-1:0];
          CFG_LP_FACTOR: lp_factor = cfg_data_i[FACTOR_WIDTH-1:0];
          CFG_BYPASS:    bypass = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_samples.size() == 0) begin
          flag($sformatf("unexpected item, sample_out %0d", out_mon.sample_out));
        end else begin
          want = expected_samples.pop_front();
          if (out_mon.sample_out !== want) begin
            flag($sformatf("sample_out mismatch: expected %0d got %0d", want,
                           out_mon.sample_out));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_samples.push_back(bandpass_step(in_mon.sample_in));
      end
      fail_count_o  <= mismatches;
      outstanding_o <= expected_samples.size();
    end
  end

endmodule

FILE: test/tb_rc_bandpass_filter_step.sv
`timescale 1ns / 1ps
// tb_rc_bandpass_filter_step: stimulus, configuration phases and verdict for the rc band-pass block
// depends on rcbp_pkg, rcbp_if, rc_bandpass_filter_step and rcbp_scoreboard
module tb_rc_bandpass_filter_step;
  import rcbp_pkg::*;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_NO_REG = 2'd3;
  localparam int BLOCKS_PER_MODE = 7;
  localparam int ITEMS_PER_BLOCK = 83;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx;
  logic [CFG_WIDTH-1:0]     cfg_data;
  int                       tx_idle_pct = 18;
  int                       rx_idle_pct = 71;
  int                       fail_count;
  int                       outstanding;

  rcbp_in_if  in_ch ();
  rcbp_out_if out_ch ();

  rc_bandpass_filter_step uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  rcbp_scoreboard filter_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #10_000_000;
    $display("FAIL rc_bandpass_filter_step");
    $finish;
  end

  task automatic send_sample(input sample_t s);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.sample_in <= sample_t'($urandom);
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= s;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // drop valid and wait until every predicted sample has come out
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic factor_t pick_factor();
    case ($urandom_range(4))
      0: return '1;
      1: return '0;
      2: return factor_t'($urandom_range(65535, 60000));
      default: return factor_t'($urandom);
    endcase
  endfunction

  task automatic random_block();
    int      style;
    int      period;
    int      amp;
    sample_t level;
    sample_t s;
    style  = $urandom_range(3);
    period = $urandom_range(12, 1);
    amp    = ($urandom_range(3) == 0) ? 32767 : $urandom_range(32767);
    level  = sample_t'($urandom);
    for (int i = 0; i < ITEMS_PER_BLOCK; i++) begin
      case (style)
        0: s = sample_t'($urandom);
        1: begin
          level = sample_t'(int'(level) + int'($urandom_range(600)) - 300);
          s = level;
        end
        2: s = ((i / period) % 2) ? sample_t'(amp) : sample_t'(-amp - 1);
        default: s = sample_t'(int'($urandom_range(16)) - 8);
      endcase
      send_sample(s);
    end
  endtask

  initial begin
    sample_t corner_samples[9];
    corner_samples = '{sample_t'(0), SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN,
                       sample_t'(1), sample_t'(-1), 16'sh5555, 16'shAAAA};
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_HP_FACTOR;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset factors, full-scale steps and alternating bit patterns
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    drain();
    write_reg(CFG_BYPASS, CFG_WIDTH'(1));
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(16'sh00FF);
    drain();
    write_reg(CFG_BYPASS, CFG_WIDTH'(0));
    // largest factors, driving the states into saturation
    write_reg(CFG_HP_FACTOR, '1);
    write_reg(CFG_LP_FACTOR, '1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(sample_t'(0));
    drain();
    write_reg(CFG_HP_FACTOR, '0);
    write_reg(CFG_LP_FACTOR, '0);
    send_sample(SAMPLE_MAX);
    send_sample(sample_t'(-5));
    drain();
    // unknown index must leave the factors alone; half factors give rounding ties
    write_reg(CFG_NO_REG, '1);
    write_reg(CFG_HP_FACTOR, 16'h8000);
    write_reg(CFG_LP_FACTOR, 16'h8000);
    send_sample(sample_t'(1));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(3));
    send_sample(sample_t'(-3));

    for (int mode = 0; mode < 3; mode++) begin
      drain();
      case (mode)
        0: begin
          tx_idle_pct = 18;
          rx_idle_pct = 71;
        end
        1: begin
          tx_idle_pct = 71;
          rx_idle_pct = 18;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < BLOCKS_PER_MODE; blk++) begin
        drain();
        write_reg(CFG_HP_FACTOR, pick_factor());
        write_reg(CFG_LP_FACTOR, pick_factor());
        write_reg(CFG_BYPASS, CFG_WIDTH'($urandom_range(5) == 0));
        random_block();
      end
    end

    drain();
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS rc_bandpass_filter_step");
    end else begin
      $display("FAIL rc_bandpass_filter_step");
    end
    $finish;
  end

endmodule

FILE: rc_bandpass_filter_step.f
hw/rtl/rcbp_pkg.sv
hw/rtl/rcbp_if.sv
hw/rtl/rcbp_smul.sv
hw/rtl/rc_bandpass_filter_step.sv
hw/rtl/rcbp_checker.sv
test/rcbp_checker.sv
test/tb_rc_bandpass_filter_step.sv
